// ----- rtl/jlis_pkg.sv -----
// ----------------------------------------------------------------------------
// jlis_pkg
// Shared codes, constants and control types for the joined longest
// increasing subsequence block.
// ----------------------------------------------------------------------------
package jlis_pkg;

   // request codes
   localparam logic [1:0] REQ_APPEND_A = 2'd0;
   localparam logic [1:0] REQ_APPEND_B = 2'd1;
   localparam logic [1:0] REQ_SOLVE    = 2'd2;

   // element width and base score of a table entry
   localparam int ELEM_W    = 32;
   localparam int BEST_BASE = 2;

   // control from the sequencer to the shared compare unit
   typedef struct packed {
      logic load_top;    // latch the bound of the current entry
      logic ia_nz;       // something taken from sequence a
      logic jb_nz;       // something taken from sequence b
      logic scan_vld;    // scan data valid this cycle
      logic scan_src_b;  // scan data comes from sequence b
   } jlis_ctrl_type;

endpackage

// ----- rtl/jlis_ram.sv -----
// ----------------------------------------------------------------------------
// jlis_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module jlis_ram #(
   parameter int DW = 32,
   parameter int AW = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [(1 << AW)];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/jlis_best_unit.sv -----
// ----------------------------------------------------------------------------
// jlis_best_unit
// Shared signed comparator with the bound and best-score registers of the
// table entry under work.
// ----------------------------------------------------------------------------
module jlis_best_unit
   import jlis_pkg::*;
#(
   parameter int TW = 8
) (
   input  logic              clock,
   input  jlis_ctrl_type     ctrl,
   input  logic [ELEM_W-1:0] a_rd,
   input  logic [ELEM_W-1:0] b_rd,
   input  logic [TW-1:0]     tab_rd,
   output logic [TW-1:0]     best
);

   logic              bounded_ff, bounded_in;
   logic [ELEM_W-1:0] top_ff, top_in;
   logic [TW-1:0]     best_ff, best_in;
   logic [ELEM_W-1:0] cmp_x, cmp_y;
   logic              gt;
   logic [TW-1:0]     cand;

   // the one comparator: b against a for the bound, element against bound in scan
   always_comb begin
      if (ctrl.load_top) begin
         cmp_x = b_rd;
         cmp_y = a_rd;
      end else begin
         cmp_x = ctrl.scan_src_b ? b_rd : a_rd;
         cmp_y = top_ff;
      end
      gt   = $signed(cmp_x) > $signed(cmp_y);
      cand = tab_rd + TW'(1);
   end

   // bound and best update
   always_comb begin
      bounded_in = bounded_ff;
      top_in     = top_ff;
      best_in    = best_ff;
      if (ctrl.load_top) begin
         bounded_in = ctrl.ia_nz | ctrl.jb_nz;
         top_in     = (ctrl.jb_nz && (!ctrl.ia_nz || gt)) ? b_rd : a_rd;
         best_in    = TW'(BEST_BASE);
      end else if (ctrl.scan_vld) begin
         if ((!bounded_ff || gt) && (cand > best_ff)) begin
            best_in = cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      bounded_ff <= bounded_in;
      top_ff     <= top_in;
      best_ff    <= best_in;
   end

   assign best = best_ff;

endmodule

// ----- rtl/joined_longest_increasing_subseq_top.sv -----
// ----------------------------------------------------------------------------
// joined_longest_increasing_subseq_top
// Loads sequences a and b and, on a solve request, fills the length table
// in reverse index order to find the longest joined increasing subsequence.
// ----------------------------------------------------------------------------
// Usage:
//  - request channel (req_valid / req_stall): req_type 0 appends
//    req_elem_value to a, 1 appends it to b, 2 solves, 3 is ignored.
//  - appends are taken one per cycle while no solve runs; an append to a full
//    sequence is dropped and reported on the next result as overflow.
//  - a solve walks every entry (ia, jb), ia = na..0, jb = nb..0, one memory
//    read per cycle through one shared comparator. Each entry passes S_TOP,
//    S_TOPLD, S_SCAN_A, S_SCAN_B and S_WRITE in that order, and the result
//    (rsp_valid / rsp_stall) is valid once the last entry is written.
//  - requests stall while a solve runs; a further solve also stalls while
//    the previous result is still waiting to be taken, appends do not.
//  - a result holds while rsp_stall is high.
//  - reset clears the counts, the overflow flag and the pending result;
//    element and table memories hold no reset value and need no clearing.
//  - a solve clears the counts and the overflow flag for the next case.
// ----------------------------------------------------------------------------
module joined_longest_increasing_subseq_top
   import jlis_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_type,
   input  logic signed [ELEM_W-1:0] req_elem_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_joined_length,
   output logic                     rsp_overflow
);

   localparam int IDX_W = $clog2(MAX_LEN + 1);
   localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int TW    = $clog2(2 * MAX_LEN + 3);
   localparam int RW    = (TW > 8) ? TW : 8;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TOP    = 3'd1;
   localparam logic [2:0] S_TOPLD  = 3'd2;
   localparam logic [2:0] S_SCAN_A = 3'd3;
   localparam logic [2:0] S_SCAN_B = 3'd4;
   localparam logic [2:0] S_WRITE  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_a_ff, cnt_a_in;
   logic [IDX_W-1:0] cnt_b_ff, cnt_b_in;
   logic             drop_ff, drop_in;
   logic [IDX_W-1:0] ia_ff, ia_in;
   logic [IDX_W-1:0] jb_ff, jb_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             pv_ff, pv_in;
   logic             psrc_ff, psrc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_len_ff, rsp_len_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic              req_acc;
   logic              a_wr, b_wr;
   logic [AW-1:0]     a_rd_addr, b_rd_addr;
   logic [ELEM_W-1:0] a_rd, b_rd;
   logic [IDX_W-1:0]  k_nx, ia_m1, jb_m1;
   logic [2*IDX_W-1:0] tab_rd_addr;
   logic [TW-1:0]     tab_rd;
   logic              tab_wr;
   logic [TW-1:0]     best;
   logic [RW-1:0]     res_w;
   jlis_ctrl_type     ctrl;

   // request handshake
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && (req_type == REQ_SOLVE));
   assign req_acc   = req_valid && !req_stall;
   assign a_wr      = req_acc && (req_type == REQ_APPEND_A) && (cnt_a_ff < IDX_W'(MAX_LEN));
   assign b_wr      = req_acc && (req_type == REQ_APPEND_B) && (cnt_b_ff < IDX_W'(MAX_LEN));

   // memory addressing
   assign k_nx  = k_ff + IDX_W'(1);
   assign ia_m1 = ia_ff - IDX_W'(1);
   assign jb_m1 = jb_ff - IDX_W'(1);
   assign a_rd_addr   = (state_ff == S_TOP) ? ia_m1[AW-1:0] : k_ff[AW-1:0];
   assign b_rd_addr   = (state_ff == S_TOP) ? jb_m1[AW-1:0] : k_ff[AW-1:0];
   assign tab_rd_addr = (state_ff == S_SCAN_A) ? {k_nx, jb_ff} : {ia_ff, k_nx};
   assign tab_wr      = (state_ff == S_WRITE);

   jlis_ram #(.DW(ELEM_W), .AW(AW)) u_seq_a (
      .clock   (clock),
      .wr_en   (a_wr),
      .wr_addr (cnt_a_ff[AW-1:0]),
      .wr_data (req_elem_value),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd)
   );

   jlis_ram #(.DW(ELEM_W), .AW(AW)) u_seq_b (
      .clock   (clock),
      .wr_en   (b_wr),
      .wr_addr (cnt_b_ff[AW-1:0]),
      .wr_data (req_elem_value),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd)
   );

   jlis_ram #(.DW(TW), .AW(2 * IDX_W)) u_table (
      .clock   (clock),
      .wr_en   (tab_wr),
      .wr_addr ({ia_ff, jb_ff}),
      .wr_data (best),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_rd)
   );

   // control to the shared compare unit
   always_comb begin
      ctrl.load_top   = (state_ff == S_TOPLD);
      ctrl.ia_nz      = (ia_ff != '0);
      ctrl.jb_nz      = (jb_ff != '0);
      ctrl.scan_vld   = pv_ff;
      ctrl.scan_src_b = psrc_ff;
   end

   jlis_best_unit #(.TW(TW)) u_best (
      .clock  (clock),
      .ctrl   (ctrl),
      .a_rd   (a_rd),
      .b_rd   (b_rd),
      .tab_rd (tab_rd),
      .best   (best)
   );

   // final score less the base; the sequencer saturates it to eight bits
   assign res_w = RW'(best) - RW'(BEST_BASE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      drop_in      = drop_ff;
      ia_in        = ia_ff;
      jb_in        = jb_ff;
      k_in         = k_ff;
      pv_in        = 1'b0;
      psrc_in      = psrc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_type)
                  REQ_APPEND_A: begin
                     if (a_wr) cnt_a_in = cnt_a_ff + IDX_W'(1);
                     else      drop_in  = 1'b1;
                  end
                  REQ_APPEND_B: begin
                     if (b_wr) cnt_b_in = cnt_b_ff + IDX_W'(1);
                     else      drop_in  = 1'b1;
                  end
                  REQ_SOLVE: begin
                     ia_in    = cnt_a_ff;
                     jb_in    = cnt_b_ff;
                     state_in = S_TOP;
                  end
                  default: ;
               endcase
            end
         end
         S_TOP: begin
            k_in     = ia_ff;
            state_in = S_TOPLD;
         end
         S_TOPLD: begin
            state_in = S_SCAN_A;
         end
         S_SCAN_A: begin
            if (k_ff < cnt_a_ff) begin
               pv_in   = 1'b1;
               psrc_in = 1'b0;
               k_in    = k_nx;
            end else begin
               k_in     = jb_ff;
               state_in = S_SCAN_B;
            end
         end
         S_SCAN_B: begin
            if (k_ff < cnt_b_ff) begin
               pv_in   = 1'b1;
               psrc_in = 1'b1;
               k_in    = k_nx;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (jb_ff != '0) begin
               jb_in    = jb_m1;
               state_in = S_TOP;
            end else if (ia_ff != '0) begin
               ia_in    = ia_m1;
               jb_in    = cnt_b_ff;
               state_in = S_TOP;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = (res_w > RW'(255)) ? 8'hFF : res_w[7:0];
               rsp_ovf_in   = drop_ff;
               cnt_a_in     = '0;
               cnt_b_in     = '0;
               drop_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         drop_ff      <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         drop_ff      <= drop_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // index and result payload registers
   always_ff @(posedge clock) begin
      ia_ff      <= ia_in;
      jb_ff      <= jb_in;
      k_ff       <= k_in;
      psrc_ff    <= psrc_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_joined_length = rsp_len_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule
